// ===== rtl/sli_pkg.sv =====
// Shared types and codes for the sorted list insert/delete block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sli_pkg;

    // Request kinds on the input channel
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture request, set up scan
        logic step;   // evaluate read data, shift at most one entry
        logic fin;    // place/remove, update fill and result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_end;  // no more entries to visit for this request
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sli_datapath.sv =====
// Datapath: entry table, fill count, scan index and result registers.
// Depends on sli_pkg and sli_ram.
`default_nettype none

module sli_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sli_pkg::cmd_t       cmd,
    output sli_pkg::sts_t            sts,
    input  wire logic                s_req_type,
    input  wire logic signed [31:0]  s_value,
    output logic [1:0]               m_status,
    output logic [4:0]               m_count,
    output logic                     m_empty_res,
    output logic signed [31:0]       m_smallest
);
    import sli_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic                 stop_reg, stop_next;
    logic                 type_reg, type_next;
    logic signed [31:0]   value_reg, value_next;
    logic signed [31:0]   min_reg, min_next;
    status_t              status_reg, status_next;

    logic [FW-1:0]        idx_m1;
    logic                 full;
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [31:0]          wdata, rdata;
    logic [FW+4:0]        fill_ext;

    sli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign idx_m1 = idx_reg - FW'(1);
    assign full   = (fill_reg == FW'(DEPTH));

    // Insert scans downwards from the top, delete scans upwards from the bottom
    assign raddr = (type_reg == REQ_DELETE) ? idx_reg[AW-1:0] : idx_m1[AW-1:0];
    assign sts.scan_end = (type_reg == REQ_INSERT)
                        ? (full || stop_reg || (idx_reg == '0))
                        : (idx_reg == fill_reg);

    // Next-state logic for the datapath registers and table writes
    always_comb begin
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        stop_next   = stop_reg;
        type_next   = type_reg;
        value_next  = value_reg;
        min_next    = min_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = idx_reg[AW-1:0];
        wdata       = value_reg;

        if (cmd.load) begin
            type_next  = s_req_type;
            value_next = s_value;
            found_next = 1'b0;
            stop_next  = 1'b0;
            idx_next   = (s_req_type == REQ_INSERT) ? fill_reg : '0;
        end

        if (cmd.step) begin
            if (type_reg == REQ_INSERT) begin
                // Stop once the entry below is strictly smaller, else move it up
                if (value_reg > $signed(rdata)) begin
                    stop_next = 1'b1;
                end else begin
                    we       = 1'b1;
                    wdata    = rdata;
                    idx_next = idx_m1;
                end
            end else begin
                // After the match, pull every later entry down by one
                if (found_reg) begin
                    we    = 1'b1;
                    waddr = idx_m1[AW-1:0];
                    wdata = rdata;
                end else if (rdata == value_reg) begin
                    found_next = 1'b1;
                end
                idx_next = idx_reg + FW'(1);
            end
        end

        if (cmd.fin) begin
            if (type_reg == REQ_INSERT) begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    we          = 1'b1;
                    wdata       = value_reg;
                    fill_next   = fill_reg + FW'(1);
                    status_next = ST_DONE;
                end
            end else begin
                if (found_reg) begin
                    fill_next   = fill_reg - FW'(1);
                    status_next = ST_DONE;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
        end

        // Track the head entry as it is written
        if (we && (waddr == '0)) begin
            min_next = $signed(wdata);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            stop_reg  <= 1'b0;
            type_reg  <= REQ_INSERT;
        end else begin
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            stop_reg  <= stop_next;
            type_reg  <= type_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        min_reg    <= min_next;
        status_reg <= status_next;
    end

    // Result fields
    assign fill_ext    = {5'b0, fill_reg};
    assign m_status    = status_reg;
    assign m_count     = fill_ext[4:0];
    assign m_empty_res = (fill_reg == '0);
    assign m_smallest  = (fill_reg == '0) ? 32'sd0 : min_reg;

endmodule

`default_nettype wire

// ===== rtl/sli_ctrl.sv =====
// Controller state machine: sequences the scan and both handshakes.
// Depends on sli_pkg.
`default_nettype none

module sli_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sli_pkg::cmd_t      cmd,
    input  wire sli_pkg::sts_t sts
);
    import sli_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                // The table read for the current position is issued here
                if (sts.scan_end) begin
                    cmd.fin    = 1'b1;
                    state_next = S_RESP;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.step   = 1'b1;
                state_next = S_LOOK;
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_insert_delete.sv =====
// Top level of the sorted list insert/delete block.
// Depends on sli_pkg, sli_ctrl and sli_datapath.
//
// Keeps an ascending sorted multiset of signed 32-bit values in a table of
// DEPTH entries. The input channel (s_valid/s_ready) carries one request:
// s_req_type 0 inserts s_value in order, 1 deletes the first equal entry.
// Each request yields exactly one result on the m_ channel: status (done,
// full, not found), entry count, empty flag and the smallest value held.
//
// One request is handled at a time. The table sits in a RAM with one read
// and one write port and registered read data, so each entry compared takes
// a read state (S_LOOK) and then a compare-and-move state (S_CHECK). An
// insert compares the entries it moves up plus the one it stops on, if any;
// a delete compares every entry held; a refused insert compares none. When
// the scan ends the controller enters S_RESP and offers the result. s_ready
// is high again the cycle after the result transfer.
//
// Reset empties the table at once (fill count to zero); table contents are
// not cleared. While the receiver stalls, the result holds and no new
// request is taken.
`default_nettype none

module sorted_list_insert_delete #(
    parameter int DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [4:0]              m_count,
    output logic                    m_empty_res,
    output logic signed [31:0]      m_smallest
);
    import sli_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sli_datapath #(.DEPTH(DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .m_status    (m_status),
        .m_count     (m_count),
        .m_empty_res (m_empty_res),
        .m_smallest  (m_smallest)
    );

endmodule

`default_nettype wire

// ===== rtl/sli_checker.sv =====
// Port-level checks for the sorted list insert/delete block, bound to the top.
// Depends on sli_pkg and sorted_list_insert_delete.
`default_nettype none

module sli_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_status,
    input wire logic [4:0]         m_count,
    input wire logic               m_empty_res,
    input wire logic signed [31:0] m_smallest
);
    import sli_pkg::*;

    // A stalled result stays valid and holds its status, count and smallest value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_count)
            && $stable(m_smallest))
        else $error("result changed while stalled");

    // One request at a time: never ready for input while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    // An empty table reports zero as smallest
    a_emp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_smallest == 32'sd0)
        else $error("empty table with nonzero smallest");

    // Status is always a defined code
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_DONE) || (m_status == ST_FULL)
            || (m_status == ST_NOT_FOUND))
        else $error("undefined status code");

    // A refused insert means the table is not empty
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> !m_empty_res)
        else $error("full status on empty table");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);

`default_nettype wire

// ===== tb/sorted_list_insert_delete_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_list_insert_delete: directed cases plus random insert and delete traffic
// with idling on both channels, checked against a sorted table model kept in the bench.
// Depends on sli_pkg and the sorted_list_insert_delete RTL.

module sorted_list_insert_delete_test;
    import sli_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        status_t            status;
        logic [4:0]         count;
        logic               empty;
        logic signed [31:0] smallest;
    } list_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [4:0]         m_count;
    logic               m_empty_res;
    logic signed [31:0] m_smallest;

    // Table model: sorted values in positions 0..held-1
    logic signed [31:0] sorted_vals [TABLE_DEPTH];
    int                 held;
    list_result_t       pending_results [$];

    bit no_idle;
    int mismatches;
    int results_seen;
    int inserts_sent;
    int deletes_sent;
    int refused_full;
    int absent_deletes;
    int peak_held;
    int quiet_cycles;

    sorted_list_insert_delete #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_count     (m_count),
        .m_empty_res (m_empty_res),
        .m_smallest  (m_smallest)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Apply one accepted request to the table model and queue its result
    task automatic update_sorted_table(input logic kind, input logic signed [31:0] val);
        int           pos;
        int           i;
        list_result_t res;
        pos = 0;
        res.status = ST_DONE;
        if (kind == REQ_INSERT) begin
            inserts_sent++;
            if (held >= TABLE_DEPTH) begin
                res.status = ST_FULL;
                refused_full++;
            end else begin
                while (pos < held && val > sorted_vals[pos])
                    pos++;
                for (i = held; i > pos; i--)
                    sorted_vals[i] = sorted_vals[i - 1];
                sorted_vals[pos] = val;
                held++;
            end
        end else begin
            deletes_sent++;
            while (pos < held && sorted_vals[pos] != val)
                pos++;
            if (pos >= held) begin
                res.status = ST_NOT_FOUND;
                absent_deletes++;
            end else begin
                for (i = pos; i + 1 < held; i++)
                    sorted_vals[i] = sorted_vals[i + 1];
                held--;
            end
        end
        if (held > peak_held)
            peak_held = held;
        res.count    = 5'(held);
        res.empty    = (held == 0);
        res.smallest = (held == 0) ? 32'sd0 : sorted_vals[0];
        pending_results.push_back(res);
    endtask

    // Present one request after a random gap and hold it until the transfer
    task automatic send_request(input logic kind, input logic signed [31:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        update_sorted_table(kind, val);
    endtask

    // Values that collide or are already held, with extremes and wide noise
    function automatic logic signed [31:0] draw_value(input logic kind);
        int sel;
        sel = $urandom_range(0, 9);
        if (kind == REQ_DELETE && held > 0 && sel < 6)
            return sorted_vals[$urandom_range(0, held - 1)];
        case (sel)
            0, 1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            4: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic test_empty_table();
        send_request(REQ_DELETE, 32'sd0);
        send_request(REQ_DELETE, 32'sh80000000);
    endtask

    task automatic test_extremes_and_duplicates();
        send_request(REQ_INSERT, 32'sh7fffffff);
        send_request(REQ_INSERT, 32'sh80000000);
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_DELETE, 32'sd1234);
        send_request(REQ_DELETE, 32'sh80000000);
        send_request(REQ_DELETE, 32'sd5);
    endtask

    task automatic test_full_table();
        while (held < TABLE_DEPTH)
            send_request(REQ_INSERT, draw_value(REQ_INSERT));
        send_request(REQ_INSERT, 32'sd3);
        send_request(REQ_DELETE, 32'sh7fffffff);
        send_request(REQ_INSERT, 32'sh80000000);
    endtask

    // Random traffic weighted towards inserts or deletes
    task automatic test_random_traffic(input int items, input int insert_pct);
        logic kind;
        int   n;
        for (n = 0; n < items; n++) begin
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
            send_request(kind, draw_value(kind));
        end
    endtask

    task automatic test_grow_and_shrink();
        int round;
        for (round = 0; round < 4; round++) begin
            no_idle = (round == 2);
            test_random_traffic(90, 80);
            test_random_traffic(90, 20);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_balanced_mix();
        no_idle = 1'b1;
        test_random_traffic(140, 50);
        no_idle = 1'b0;
        test_random_traffic(140, 50);
    endtask

    // Release the input channel, drain the results and let the block settle
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stall before taking each result
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        list_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result status=%0d count=%0d empty=%0b smallest=%0d",
                             $realtime, m_status, m_count, m_empty_res, m_smallest);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_status !== exp_res.status || m_count !== exp_res.count ||
                    m_empty_res !== exp_res.empty || m_smallest !== exp_res.smallest) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result mismatch exp status=%0d count=%0d empty=%0b smallest=%0d, got status=%0d count=%0d empty=%0b smallest=%0d",
                                 $realtime, exp_res.status, exp_res.count, exp_res.empty,
                                 exp_res.smallest, m_status, m_count, m_empty_res,
                                 m_smallest);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel transfers for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_INSERT;
        s_value      = 32'sd0;
        held         = 0;
        no_idle      = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_extremes_and_duplicates();
        test_full_table();
        test_grow_and_shrink();
        test_balanced_mix();
        wait_for_drain();

        // Expectations still waiting count as failures
        mismatches += pending_results.size();
        $display("Sent %0d inserts and %0d deletes: %0d refused on a full table, %0d not found.",
                 inserts_sent, deletes_sent, refused_full, absent_deletes);
        $display("Checked %0d results, peak fill %0d of %0d, %0d mismatches.",
                 results_seen, peak_held, TABLE_DEPTH, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sli_pkg.sv
rtl/sli_ram.sv
rtl/sli_datapath.sv
rtl/sli_ctrl.sv
rtl/sorted_list_insert_delete.sv
rtl/sli_checker.sv
tb/sorted_list_insert_delete_test.sv
